FILE: hw/rtl/bvm_pkg.sv
`default_nettype none

package bvm_pkg;

    // sample store geometry
    localparam int NUM_SAMPLES = 10;
    localparam int SAMPLE_W    = 12;
    localparam int SUM_W       = 16;
    localparam int SLOT_W      = (NUM_SAMPLES > 1) ? $clog2(NUM_SAMPLES) : 1;

    // configuration widths
    localparam int THRESH_W = 12;
    localparam int LIMIT_W  = 8;
    localparam int GAIN_W   = 16;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 2;

    // result widths
    localparam int VOLT_W   = 12;
    localparam int STREAK_W = 8;

    // scaling: divide by NUM_SAMPLES * 4096
    localparam int PROD_W   = SUM_W + GAIN_W;
    localparam int FRAC_W   = 12;
    localparam int XSH_W    = PROD_W - FRAC_W;
    localparam int XLOW_W   = $clog2(NUM_SAMPLES * (1 << FRAC_W));
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP_W  = RECIP_SHIFT + 1;
    localparam int QPROD_W  = XLOW_W + RECIP_W;

    // reciprocal of NUM_SAMPLES, rounded up
    localparam longint unsigned RECIP_L =
        ((64'd1 << RECIP_SHIFT) + 64'(NUM_SAMPLES) - 64'd1) / 64'(NUM_SAMPLES);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);

    // shifted product at or above this saturates the voltage
    localparam logic [XSH_W-1:0] X_LIMIT = XSH_W'(NUM_SAMPLES * (1 << FRAC_W));
    localparam logic [VOLT_W-1:0] VOLT_MAX = '1;
    localparam logic [STREAK_W-1:0] STREAK_MAX = '1;

    // configuration reset values
    localparam logic [THRESH_W-1:0] THRESH_RST = THRESH_W'(360);
    localparam logic [LIMIT_W-1:0]  LIMIT_RST  = LIMIT_W'(10);
    localparam logic [GAIN_W-1:0]   GAIN_RST   = GAIN_W'(330 * 11);

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOW_THRESHOLD = 2'd0,
        CFG_COUNT_LIMIT   = 2'd1,
        CFG_SCALE_GAIN    = 2'd2
    } cfg_index_t;

    // commands
    typedef enum logic {
        CMD_STORE = 1'b0,
        CMD_CHECK = 1'b1
    } cmd_t;

    typedef struct packed {
        logic                command;
        logic [SAMPLE_W-1:0] sample;
    } in_item_t;

    typedef struct packed {
        logic [VOLT_W-1:0] voltage;
        logic              battery_low;
    } out_item_t;

    // voltage handed from the scaler to the persistence stage
    typedef struct packed {
        logic              valid;
        logic [VOLT_W-1:0] voltage;
    } volt_xfer_t;

endpackage

`default_nettype wire

FILE: hw/rtl/battery_voltage_low_monitor.sv
// channel  | direction | handshake            | payload
// ---------+-----------+----------------------+-----------------------------
// in       | input     | in_valid / in_ready  | in_data: command, sample
// out      | output    | out_valid / out_ready| out_data: voltage, battery_low
// cfg      | input     | cfg_wr_en            | cfg_index, cfg_data
//
// one item per cycle if in_ready is high; a store ends at its transfer edge
// a check raises out_valid after the gain multiply, the reciprocal multiply,
// then the threshold compare into the result register
// in_ready drops only while both scaler stages and the result register are full
// and out_ready is low
// reset clears the sample ring, sum, write slot, streak and registers to defaults
`default_nettype none

module battery_voltage_low_monitor
    import bvm_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire in_item_t             in_data,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output out_item_t                 out_data,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    logic [THRESH_W-1:0] thresh_reg;
    logic [LIMIT_W-1:0]  limit_reg;
    logic [GAIN_W-1:0]   gain_reg;
    logic                accept;
    logic                store;
    logic                check;
    logic [SUM_W-1:0]    sum;
    volt_xfer_t          volt;
    logic                persist_ready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= THRESH_RST;
            limit_reg  <= LIMIT_RST;
            gain_reg   <= GAIN_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_LOW_THRESHOLD: thresh_reg <= cfg_data[THRESH_W-1:0];
                CFG_COUNT_LIMIT:   limit_reg  <= cfg_data[LIMIT_W-1:0];
                CFG_SCALE_GAIN:    gain_reg   <= cfg_data[GAIN_W-1:0];
                default:           ;
            endcase
        end
    end

    // input transfer decode
    assign accept = in_valid && in_ready;
    assign store  = accept && (in_data.command == CMD_STORE);
    assign check  = accept && (in_data.command == CMD_CHECK);

    bvm_sample_store u_store (
        .clk    (clk),
        .rst_n  (rst_n),
        .store  (store),
        .sample (in_data.sample),
        .sum    (sum)
    );

    bvm_scale u_scale (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (check),
        .sum          (sum),
        .gain         (gain_reg),
        .ready        (in_ready),
        .result       (volt),
        .result_ready (persist_ready)
    );

    bvm_persist u_persist (
        .clk       (clk),
        .rst_n     (rst_n),
        .volt_in   (volt),
        .ready     (persist_ready),
        .threshold (thresh_reg),
        .limit     (limit_reg),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/bvm_sample_store.sv
`default_nettype none

module bvm_sample_store
    import bvm_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                store,
    input  wire logic [SAMPLE_W-1:0] sample,
    output logic      [SUM_W-1:0]    sum
);

    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(NUM_SAMPLES - 1);

    logic [SAMPLE_W-1:0] ring_reg [NUM_SAMPLES];
    logic [SLOT_W-1:0]   slot_reg;
    logic [SLOT_W-1:0]   slot_next;
    logic [SUM_W-1:0]    sum_reg;
    logic [SUM_W-1:0]    sum_next;

    // oldest entry leaves the sum, new sample enters
    always_comb
    begin
        sum_next  = sum_reg - SUM_W'(ring_reg[slot_reg]) + SUM_W'(sample);
        slot_next = (slot_reg == SLOT_LAST) ? '0 : slot_reg + SLOT_W'(1);
    end

    // ring, write slot and running sum
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SAMPLES; i++)
            begin
                ring_reg[i] <= '0;
            end
            slot_reg <= '0;
            sum_reg  <= '0;
        end
        else if (store)
        begin
            ring_reg[slot_reg] <= sample;
            slot_reg           <= slot_next;
            sum_reg            <= sum_next;
        end
    end

    assign sum = sum_reg;

    // write slot stays inside the ring
    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        slot_reg <= SLOT_LAST)
        else $error("write slot out of range");

endmodule

`default_nettype wire

FILE: hw/rtl/bvm_scale.sv
`default_nettype none

module bvm_scale
    import bvm_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [SUM_W-1:0]  sum,
    input  wire logic [GAIN_W-1:0] gain,
    output logic                   ready,
    output volt_xfer_t             result,
    input  wire logic              result_ready
);

    logic                 v1_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [PROD_W-1:0]    prod_next;
    logic                 v2_reg;
    logic [VOLT_W-1:0]    volt_reg;
    logic [VOLT_W-1:0]    volt_next;
    logic                 ready1;
    logic                 ready2;
    logic [XSH_W-1:0]     xsh;
    logic [QPROD_W-1:0]   qprod;

    // stage handshake
    assign ready2 = !v2_reg || result_ready;
    assign ready1 = !v1_reg || ready2;
    assign ready  = ready1;

    // sum times gain
    assign prod_next = PROD_W'(sum) * PROD_W'(gain);

    // drop the 4096 by shift, divide by the sample count via reciprocal
    always_comb
    begin
        xsh   = prod_reg[PROD_W-1:FRAC_W];
        qprod = QPROD_W'(xsh[XLOW_W-1:0]) * QPROD_W'(RECIP);
        if (xsh >= X_LIMIT)
        begin
            volt_next = VOLT_MAX;
        end
        else
        begin
            volt_next = qprod[RECIP_SHIFT +: VOLT_W];
        end
    end

    // stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (ready1)
            begin
                v1_reg <= start;
            end
            if (ready2)
            begin
                v2_reg <= v1_reg;
            end
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (ready1 && start)
        begin
            prod_reg <= prod_next;
        end
        if (ready2 && v1_reg)
        begin
            volt_reg <= volt_next;
        end
    end

    assign result.valid   = v2_reg;
    assign result.voltage = volt_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/bvm_persist.sv
`default_nettype none

module bvm_persist
    import bvm_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire volt_xfer_t          volt_in,
    output logic                     ready,
    input  wire logic [THRESH_W-1:0] threshold,
    input  wire logic [LIMIT_W-1:0]  limit,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output out_item_t                out_data
);

    logic                out_valid_reg;
    out_item_t           out_reg;
    out_item_t           out_next;
    logic [STREAK_W-1:0] streak_reg;
    logic [STREAK_W-1:0] streak_next;
    logic                is_low;
    logic                load;

    assign ready = !out_valid_reg || out_ready;
    assign load  = volt_in.valid && ready;

    // low streak count and flag
    always_comb
    begin
        is_low = volt_in.voltage < VOLT_W'(threshold);
        if (!is_low)
        begin
            streak_next = '0;
        end
        else if (streak_reg == STREAK_MAX)
        begin
            streak_next = streak_reg;
        end
        else
        begin
            streak_next = streak_reg + STREAK_W'(1);
        end
        out_next.voltage     = volt_in.voltage;
        out_next.battery_low = is_low && (streak_next > STREAK_W'(limit));
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            streak_reg    <= '0;
        end
        else
        begin
            if (ready)
            begin
                out_valid_reg <= volt_in.valid;
            end
            if (load)
            begin
                streak_reg <= streak_next;
            end
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // a raised flag always comes with a running streak
    a_flag_streak: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.battery_low |-> streak_reg != '0)
        else $error("low flag without low streak");

    // a check at or above threshold clears the streak
    a_clear_streak: assert property (@(posedge clk) disable iff (!rst_n)
        load && !is_low |=> streak_reg == '0)
        else $error("streak not cleared");

    // streak only steps up by one or drops to zero
    a_streak_step: assert property (@(posedge clk) disable iff (!rst_n)
        streak_reg != $past(streak_reg) |->
            streak_reg == '0 || streak_reg == $past(streak_reg) + STREAK_W'(1))
        else $error("streak jumped");

endmodule

`default_nettype wire

FILE: test/tb.sv
`timescale 1ns / 1ps

module tb;
    import bvm_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int LONG_HOLD     = 64;
    localparam int FULL_SCALE    = 4096;
    localparam int SAT_BURST     = 300;
    localparam int RANDOM_PHASES = 9;
    localparam int PHASE_ITEMS   = 92;
    localparam int REPORT_MAX    = 10;

    // predicts voltage and low flag from the sample ring, streak and registers
    class low_voltage_tracker;
        logic [SAMPLE_W-1:0] ring [NUM_SAMPLES];
        int unsigned         slot;
        logic [SUM_W-1:0]    sum;
        logic [STREAK_W-1:0] streak;
        logic [THRESH_W-1:0] threshold;
        logic [LIMIT_W-1:0]  limit;
        logic [GAIN_W-1:0]   gain;
        out_item_t           voltages_due[$];
        int unsigned         mismatches;
        int unsigned         stores;
        int unsigned         checks;
        int unsigned         low_flags;
        int unsigned         saturated;

        function new();
            foreach (ring[i])
                ring[i] = '0;
            slot       = 0;
            sum        = '0;
            streak     = '0;
            threshold  = THRESH_RST;
            limit      = LIMIT_RST;
            gain       = GAIN_RST;
            mismatches = 0;
            stores     = 0;
            checks     = 0;
            low_flags  = 0;
            saturated  = 0;
        endfunction

        function void set_reg(cfg_index_t idx, logic [CFG_W-1:0] value);
            case (idx)
                CFG_LOW_THRESHOLD: threshold = value[THRESH_W-1:0];
                CFG_COUNT_LIMIT:   limit = value[LIMIT_W-1:0];
                CFG_SCALE_GAIN:    gain = value[GAIN_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return voltages_due.size();
        endfunction

        function void flag_error(string msg);
            mismatches++;
            if (mismatches <= REPORT_MAX)
                $display("mismatch: %s", msg);
        endfunction

        // one accepted input transfer
        function void take_item(in_item_t item);
            logic [31:0] product;
            logic [31:0] quotient;
            out_item_t   result;
            // store: replace the oldest sample and adjust the sum
            if (item.command == CMD_STORE) begin
                sum = sum - SUM_W'(ring[slot]) + SUM_W'(item.sample);
                ring[slot] = item.sample;
                slot = (slot == NUM_SAMPLES - 1) ? 0 : slot + 1;
                stores++;
                return;
            end
            // check: scale the sum, saturate, then update the low streak
            product  = 32'(sum) * 32'(gain);
            quotient = product / 32'(NUM_SAMPLES * FULL_SCALE);
            if (quotient > 32'(VOLT_MAX)) begin
                result.voltage = VOLT_MAX;
                saturated++;
            end
            else begin
                result.voltage = quotient[VOLT_W-1:0];
            end
            if (result.voltage < threshold) begin
                if (streak != STREAK_MAX)
                    streak++;
                result.battery_low = (streak > limit);
            end
            else begin
                streak = '0;
                result.battery_low = 1'b0;
            end
            checks++;
            if (result.battery_low)
                low_flags++;
            voltages_due.push_back(result);
        endfunction

        // one accepted output transfer against the oldest prediction
        function void match_result(out_item_t got);
            out_item_t want;
            if (voltages_due.size() == 0) begin
                flag_error($sformatf("result with nothing due: voltage=%0d battery_low=%0b",
                                     got.voltage, got.battery_low));
                return;
            end
            want = voltages_due.pop_front();
            if (got.voltage !== want.voltage)
                flag_error($sformatf("voltage expected %0d actual %0d",
                                     want.voltage, got.voltage));
            if (got.battery_low !== want.battery_low)
                flag_error($sformatf("battery_low expected %0b actual %0b (voltage %0d)",
                                     want.battery_low, got.battery_low, want.voltage));
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    in_item_t             in_data = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    out_item_t            out_data;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    low_voltage_tracker tracker;
    int unsigned        send_idle_pct = 0;
    int unsigned        recv_idle_pct = 0;
    int unsigned        items_sent = 0;
    int unsigned        reg_writes = 0;
    int unsigned        cycle_count = 0;
    int unsigned        hold_left = 0;
    bit                 hold_req = 1'b0;

    battery_voltage_low_monitor dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // cycle limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still due",
                     cycle_count, tracker.pending());
            $display("== FAIL ==");
            $finish;
        end
    end

    // receiver: random stalls, or a long hold-off when requested
    always @(posedge clk)
    begin
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = LONG_HOLD;
        end
        if (hold_left != 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // transfer monitors
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            tracker.take_item(in_data);
        if (rst_n && out_valid && out_ready)
            tracker.match_result(out_data);
    end

    // offer one item and hold it until the transfer
    task automatic send_item(input cmd_t cmd, input logic [SAMPLE_W-1:0] value);
        in_item_t item;
        item.command = cmd;
        item.sample  = value;
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
    endtask

    // stop offering and let every due result come out
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic put_reg(input cfg_index_t idx, input logic [CFG_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        tracker.set_reg(idx, value);
        reg_writes++;
    endtask

    // register writes only once the block is idle
    task automatic write_regs(input logic [THRESH_W-1:0] thr, input logic [LIMIT_W-1:0] lim,
                              input logic [GAIN_W-1:0] gain);
        wait_drained();
        put_reg(CFG_LOW_THRESHOLD, CFG_W'(thr));
        put_reg(CFG_COUNT_LIMIT, CFG_W'(lim));
        put_reg(CFG_SCALE_GAIN, CFG_W'(gain));
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    // samples mostly around the level that puts the voltage at the threshold
    function automatic logic [SAMPLE_W-1:0] pick_sample(int unsigned level);
        int unsigned roll;
        int          v;
        roll = $urandom_range(99);
        if (roll < 50)
            v = int'(level) + int'($urandom_range(128)) - 64;
        else if (roll < 75)
            v = int'($urandom_range(4095));
        else if (roll < 85)
            v = ($urandom_range(1) == 1) ? 4095 : 0;
        else
            v = int'(level);
        if (v < 0)
            v = 0;
        if (v > 4095)
            v = 4095;
        return SAMPLE_W'(v);
    endfunction

    task automatic directed_part();
        int k;
        // empty ring at reset settings reads as zero volts
        send_item(CMD_CHECK, '0);
        // full-scale samples fill the ring and wrap the write slot
        for (k = 0; k < NUM_SAMPLES; k++)
            send_item(CMD_STORE, '1);
        send_item(CMD_CHECK, '0);
        send_item(CMD_STORE, '0);
        send_item(CMD_STORE, SAMPLE_W'(1));
        send_item(CMD_CHECK, '1);
        // largest gain saturates the voltage, largest threshold is never reached
        write_regs('1, '0, '1);
        send_item(CMD_CHECK, '0);
        send_item(CMD_CHECK, '1);
        // zero gain against a zero threshold never counts as low
        write_regs('0, LIMIT_W'(254), '0);
        send_item(CMD_CHECK, '0);
        send_item(CMD_CHECK, '0);
        // zero gain, zero limit: flag on the first low check
        write_regs(THRESH_W'(1), '0, '0);
        send_item(CMD_CHECK, '0);
        send_item(CMD_CHECK, '1);
        // limit of 255 can never be exceeded
        write_regs(THRESH_W'(1), '1, '0);
        send_item(CMD_CHECK, '0);
        send_item(CMD_CHECK, '1);
    endtask

    // store runs followed by check runs, with some single random items
    task automatic random_phase(input logic [THRESH_W-1:0] thr, input logic [LIMIT_W-1:0] lim,
                                input logic [GAIN_W-1:0] gain, input int unsigned count);
        int unsigned level;
        int unsigned start;
        int unsigned run;
        int unsigned k;
        bit          paused;
        write_regs(thr, lim, gain);
        if (gain == 0)
            level = $urandom_range(4095);
        else
            level = (int'(thr) * FULL_SCALE) / int'(gain);
        if (level > 4095)
            level = 4095;
        start  = items_sent;
        paused = 1'b0;
        while (items_sent - start < count) begin
            if ($urandom_range(9) < 7) begin
                run = $urandom_range(NUM_SAMPLES, 1);
                for (k = 0; k < run; k++)
                    send_item(CMD_STORE, pick_sample(level));
                run = $urandom_range((int'(lim) > 16) ? 20 : int'(lim) + 3, 1);
                for (k = 0; k < run; k++)
                    send_item(CMD_CHECK, SAMPLE_W'($urandom));
            end
            else begin
                send_item(($urandom_range(1) == 1) ? CMD_CHECK : CMD_STORE,
                          SAMPLE_W'($urandom));
            end
            // sender pause until everything due has come out
            if (!paused && (items_sent - start) >= count / 2) begin
                wait_drained();
                paused = 1'b1;
            end
        end
    endtask

    // long low run saturates the streak, starting with a receiver hold-off
    task automatic streak_burst();
        write_regs('1, LIMIT_W'(254), '0);
        hold_req = 1'b1;
        repeat (SAT_BURST) send_item(CMD_CHECK, SAMPLE_W'($urandom));
        wait_drained();
    endtask

    initial
    begin
        int p;
        tracker = new();
        send_idle_pct = 17;
        recv_idle_pct = 79;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_part();

        for (p = 0; p < RANDOM_PHASES; p++) begin
            // idling: sender light and receiver heavy, then swapped, then none
            if (p == 3) begin
                send_idle_pct = 79;
                recv_idle_pct = 17;
            end
            if (p == 6) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (p)
                0: random_phase(THRESH_RST, LIMIT_RST, GAIN_RST, PHASE_ITEMS);
                1: random_phase('1, '0, '1, PHASE_ITEMS);
                2: random_phase(THRESH_W'($urandom), '1, GAIN_W'($urandom_range(65535, 256)),
                                PHASE_ITEMS);
                default: random_phase(THRESH_W'($urandom), LIMIT_W'($urandom_range(12)),
                                      GAIN_W'($urandom_range(65535, 256)), PHASE_ITEMS);
            endcase
        end

        streak_burst();
        wait_drained();

        $display("covered %0d stores and %0d checks, %0d register writes, %0d cycles",
                 tracker.stores, tracker.checks, reg_writes, cycle_count);
        $display("low flag raised on %0d checks, voltage saturated on %0d, %0d mismatches",
                 tracker.low_flags, tracker.saturated, tracker.mismatches);
        if (tracker.mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/bvm_pkg.sv
hw/rtl/bvm_sample_store.sv
hw/rtl/bvm_scale.sv
hw/rtl/bvm_persist.sv
hw/rtl/battery_voltage_low_monitor.sv
test/tb.sv
